>>> hdl/acpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package acpp_pkg;

	// buffer and meter geometry
	localparam int BANK_WORDS  = 131072;
	localparam int PEAK_WINDOW = 4096;
	localparam int IDX_W       = $clog2(BANK_WORDS);
	localparam int HALF_W      = IDX_W - 1;
	localparam int WIN_W       = $clog2(PEAK_WINDOW + 1);

	// field widths
	localparam int SMP_W = 24;
	localparam int MAG_W = 23;
	localparam int CNT_W = 18;

	localparam logic [MAG_W-1:0] MAG_MAX        = 23'h7F_FFFF;
	localparam logic [MAG_W-1:0] ONE_Q20        = 23'd1048576;
	localparam logic [MAG_W-1:0] PEAK_FLOOR_RST = 23'd22;

	// register map, index = paddr[2]
	localparam int  ADDR_W     = 3;
	localparam logic REG_STEREO = 1'b0;
	localparam logic REG_FLOOR  = 1'b1;

	// stream widths
	localparam int IN_W  = 56;
	localparam int OUT_W = 96;

	typedef struct packed {
		logic             valid;
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             last_flush;
	} flush_t;

	typedef struct packed {
		logic [MAG_W-1:0] held;
		logic             clip;
	} meter_t;

	typedef struct packed {
		logic [SMP_W-1:0] left;
		logic [SMP_W-1:0] right;
		meter_t           meter;
		flush_t           flush;
	} res_t;

endpackage
`default_nettype wire

>>> hdl/audio_capture_pingpong_peak_top.sv
// a result is registered in the output queue, passing through its skid register when the
// receiver stalls; throughput: one frame per cycle while the skid is empty; the store writes
// a stereo pair at once through separate even and odd word memories; the output queue holds two entries
// reset: arst_n clears write index, bank, peak window and queue at once; registers return
// to mono and a peak floor of 22; the sample memories are not cleared and are never read
`timescale 1ns / 1ps
`default_nettype none
module audio_capture_pingpong_peak_top
	import acpp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// frame requests
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // sample_left, sample_right, record_enable, zero pad
	// result requests
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,  // out_left, out_right, held_peak, clip_flag,
	                                         // flush_valid, flush_bank, flush_count, zero pad
	output logic                   m_tlast,  // flush_final
	// register port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// configuration registers
	logic             stereo_q;
	logic [MAG_W-1:0] floor_q;
	logic             cfg_wr;

	// input unpacking
	logic [SMP_W-1:0] left;
	logic [SMP_W-1:0] right;
	logic             rec;
	logic             fire;

	meter_t meter;
	flush_t flush;
	res_t   res;
	res_t   out_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b0;
			floor_q  <= PEAK_FLOOR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_STEREO: stereo_q <= pwdata[0];
				REG_FLOOR:  floor_q  <= pwdata[MAG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_STEREO: prdata = {31'd0, stereo_q};
			REG_FLOOR:  prdata = {9'd0, floor_q};
			default:    prdata = '0;
		endcase
	end

	assign left  = s_tdata[SMP_W-1:0];
	assign right = s_tdata[2*SMP_W-1:SMP_W];
	assign rec   = s_tdata[2*SMP_W];
	// a frame is taken when the skid has room
	assign fire  = s_tvalid && s_tready;

	// windowed peak meter, held value is the one before this frame
	acpp_meter u_meter (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.stereo    (stereo_q),
		.floor_val (floor_q),
		.left      (left),
		.right     (right),
		.meter     (meter)
	);

	// ping-pong sample store with bank swap and flush reporting
	acpp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.rec    (rec),
		.stereo (stereo_q),
		.left   (left),
		.right  (right),
		.flush  (flush)
	);

	always_comb begin
		res.left  = left;
		res.right = right;
		res.meter = meter;
		res.flush = flush;
	end

	// output register with skid stage
	acpp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// result packing, lowest field first
	assign m_tdata = {4'd0,
		out_res.flush.count,
		out_res.flush.bank,
		out_res.flush.valid,
		out_res.meter.clip,
		out_res.meter.held,
		out_res.right,
		out_res.left};
	assign m_tlast = out_res.flush.last_flush;

endmodule
`default_nettype wire

>>> hdl/acpp_meter.sv
`timescale 1ns / 1ps
`default_nettype none
module acpp_meter
	import acpp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic             stereo,
	input  wire logic [MAG_W-1:0] floor_val,
	input  wire logic [SMP_W-1:0] left,
	input  wire logic [SMP_W-1:0] right,
	output meter_t                meter
);

	logic [MAG_W-1:0] run_q;
	logic [MAG_W-1:0] latch_q;
	logic [WIN_W-1:0] win_q;
	logic [MAG_W-1:0] mag_l;
	logic [MAG_W-1:0] mag_r;
	logic [MAG_W-1:0] fpeak;
	logic [MAG_W-1:0] run_max;

	// saturating absolute value
	function automatic logic [MAG_W-1:0] mag(input logic [SMP_W-1:0] s);
		logic [SMP_W-1:0] n;
		n = ~s + SMP_W'(1);
		if (!s[SMP_W-1])
			return s[MAG_W-1:0];
		else if (n[SMP_W-1])
			return MAG_MAX;
		else
			return n[MAG_W-1:0];
	endfunction

	always_comb begin
		mag_l = mag(left);
		mag_r = mag(right);
		fpeak = floor_val;
		if (mag_l > fpeak)
			fpeak = mag_l;
		if (stereo && (mag_r > fpeak))
			fpeak = mag_r;
		run_max = (fpeak > run_q) ? fpeak : run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			latch_q <= '0;
			win_q   <= '0;
		end else if (fire) begin
			if (win_q < WIN_W'(PEAK_WINDOW)) begin
				run_q <= run_max;
				win_q <= win_q + WIN_W'(1);
			end else begin
				latch_q <= run_q;
				run_q   <= fpeak;
				win_q   <= WIN_W'(1);
			end
		end
	end

	assign meter.held = latch_q;
	assign meter.clip = (latch_q >= ONE_Q20);

endmodule
`default_nettype wire

>>> hdl/acpp_store.sv
`timescale 1ns / 1ps
`default_nettype none
module acpp_store
	import acpp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic             rec,
	input  wire logic             stereo,
	input  wire logic [SMP_W-1:0] left,
	input  wire logic [SMP_W-1:0] right,
	output flush_t                flush
);

	// even and odd word addresses live in separate memories so a stereo
	// pair lands in a single write whatever the alignment
	logic [SMP_W-1:0] mem_even [BANK_WORDS];
	logic [SMP_W-1:0] mem_odd  [BANK_WORDS];

	logic [IDX_W-1:0]  idx_q;
	logic              bank_q;
	logic [HALF_W-1:0] half;
	logic              odd;
	logic              at_last;
	logic              wrap;
	logic              wr;
	logic              we_e;
	logic              we_o;
	logic [IDX_W-1:0]  addr_e;
	logic [IDX_W-1:0]  addr_o;
	logic [SMP_W-1:0]  data_e;
	logic [SMP_W-1:0]  data_o;

	always_comb begin
		half    = idx_q[IDX_W-1:1];
		odd     = idx_q[0];
		at_last = (idx_q == IDX_W'(BANK_WORDS - 1));
		wrap    = stereo ? (idx_q >= IDX_W'(BANK_WORDS - 2)) : at_last;
		wr      = fire && rec;
		// right word of a pair past the bank end is dropped
		we_e    = wr && (!odd || (stereo && !at_last));
		we_o    = wr && (odd || stereo);
		addr_e  = {bank_q, odd ? (half + HALF_W'(1)) : half};
		addr_o  = {bank_q, half};
		data_e  = odd ? right : left;
		data_o  = odd ? left : right;

		flush = '0;
		if (rec && wrap) begin
			flush.valid = 1'b1;
			flush.bank  = bank_q;
			flush.count = CNT_W'(BANK_WORDS);
		end else if (!rec && (idx_q != '0)) begin
			flush.valid      = 1'b1;
			flush.bank       = bank_q;
			flush.count      = CNT_W'(idx_q);
			flush.last_flush = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_e)
			mem_even[addr_e] <= data_e;
	end

	always_ff @(posedge clk) begin
		if (we_o)
			mem_odd[addr_o] <= data_o;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			bank_q <= 1'b0;
		end else if (fire) begin
			if (rec) begin
				if (wrap) begin
					idx_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					idx_q <= idx_q + (stereo ? IDX_W'(2) : IDX_W'(1));
				end
			end else if (idx_q != '0) begin
				idx_q  <= '0;
				bank_q <= 1'b0;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(BANK_WORDS - 1))
		else $error("write index beyond bank");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !rec) |=> (idx_q == '0))
		else $error("stop did not clear write index");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(flush.valid && !flush.last_flush) |-> (flush.count == CNT_W'(BANK_WORDS)))
		else $error("bank swap with partial count");

	a_idle_flush: assert property (@(posedge clk) disable iff (!arst_n)
		!flush.valid |-> (flush.count == '0 && !flush.last_flush && !flush.bank))
		else $error("flush fields set without flush");

endmodule
`default_nettype wire

>>> hdl/acpp_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module acpp_outq
	import acpp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire res_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_data
);

	res_t main_q;
	res_t skid_q;
	logic main_v_q;
	logic skid_v_q;

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			main_v_q <= skid_v_q || in_valid;
			skid_v_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready)
			main_q <= skid_v_q ? skid_q : in_data;
		else if (in_valid && in_ready)
			skid_q <= in_data;
	end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import acpp_pkg::*;

	// cycles without any accepted request or register access before the run is abandoned
	localparam int STALL_LIMIT = 2000;
	// mismatches printed in full, later ones are only counted
	localparam int SHOWN_MAX   = 10;
	// frames per random segment, segments in the random part
	localparam int SEG_ITEMS   = 100;
	localparam int SEG_COUNT   = 8;

	// predicts one result per frame request and checks the results in order
	class capture_scoreboard;
		logic             stereo;
		logic [MAG_W-1:0] floor_q;
		logic [IDX_W-1:0] widx;
		logic             bank;
		logic [MAG_W-1:0] run_pk;
		logic [MAG_W-1:0] latched;
		logic [WIN_W-1:0] win_cnt;
		res_t             expected_q[$];
		int               errors;
		int               checked;
		int               n_swap;
		int               n_close;
		int               n_clip;
		int               n_latch;

		function new();
			stereo  = 1'b0;
			floor_q = PEAK_FLOOR_RST;
			widx    = '0;
			bank    = 1'b0;
			run_pk  = '0;
			latched = '0;
			win_cnt = '0;
			errors  = 0;
			checked = 0;
			n_swap  = 0;
			n_close = 0;
			n_clip  = 0;
			n_latch = 0;
		endfunction

		// saturating magnitude of a Q3.20 sample
		function logic [MAG_W-1:0] mag(logic [SMP_W-1:0] v);
			logic [SMP_W-1:0] neg;
			neg = -v;
			if (v == 24'h80_0000)
				return MAG_MAX;
			else if (v[SMP_W-1])
				return neg[MAG_W-1:0];
			else
				return v[MAG_W-1:0];
		endfunction

		function void note_frame(logic [IN_W-1:0] d);
			logic [SMP_W-1:0] l;
			logic [SMP_W-1:0] r;
			logic             rec;
			logic [MAG_W-1:0] fpk;
			logic             wrap;
			res_t             e;
			l   = d[23:0];
			r   = d[47:24];
			rec = d[48];
			e = '0;
			e.left       = l;
			e.right      = r;
			e.meter.held = latched;
			e.meter.clip = (latched >= ONE_Q20);
			// frame peak: floor, left, and right only in stereo
			fpk = floor_q;
			if (mag(l) > fpk)
				fpk = mag(l);
			if (stereo && mag(r) > fpk)
				fpk = mag(r);
			if (win_cnt < PEAK_WINDOW) begin
				if (fpk > run_pk)
					run_pk = fpk;
				win_cnt++;
			end else begin
				latched = run_pk;
				run_pk  = fpk;
				win_cnt = 1;
				n_latch++;
			end
			if (rec) begin
				if (stereo) begin
					wrap = (widx >= BANK_WORDS - 2);
					widx = wrap ? '0 : widx + 17'd2;
				end else begin
					wrap = (widx >= BANK_WORDS - 1);
					widx = wrap ? '0 : widx + 17'd1;
				end
				if (wrap) begin
					e.flush.valid = 1'b1;
					e.flush.bank  = bank;
					e.flush.count = CNT_W'(BANK_WORDS);
					bank = ~bank;
				end
			end else if (widx != 0) begin
				e.flush.valid      = 1'b1;
				e.flush.bank       = bank;
				e.flush.count      = CNT_W'(widx);
				e.flush.last_flush = 1'b1;
				widx = '0;
				bank = 1'b0;
			end
			expected_q.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= SHOWN_MAX)
					$display("mismatch on result %0d, %s: expected %h, got %h",
						checked, name, want, got);
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] d, logic last);
			res_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= SHOWN_MAX)
					$display("result with no frame waiting: tdata %h tlast %b", d, last);
				return;
			end
			e = expected_q.pop_front();
			compare_field("out_left",    e.left,             d[23:0]);
			compare_field("out_right",   e.right,            d[47:24]);
			compare_field("held_peak",   e.meter.held,       d[70:48]);
			compare_field("clip_flag",   e.meter.clip,       d[71]);
			compare_field("flush_valid", e.flush.valid,      d[72]);
			compare_field("flush_bank",  e.flush.bank,       d[73]);
			compare_field("flush_count", e.flush.count,      d[91:74]);
			compare_field("pad",         32'd0,              d[95:92]);
			compare_field("flush_final", e.flush.last_flush, last);
			checked++;
			if (e.flush.valid)
				if (e.flush.last_flush)
					n_close++;
				else
					n_swap++;
			if (e.meter.clip)
				n_clip++;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	capture_scoreboard sb;
	// when set, neither side idles: bursts run at full rate
	bit                no_idle;
	int                idle_cycles;
	int                frames_sent;
	int                n_settings;
	int                run_left;

	audio_capture_pingpong_peak_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// both monitors sample before the edge's updates land, so order does not matter;
	// a result is registered in the block, so it always reaches the monitor after its frame
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_frame(s_tdata);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
	end

	// watchdog: any accepted request or register access counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d results outstanding",
				idle_cycles, sb.expected_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: bursts of ready broken by stalls, mostly short, now and then long
	initial begin
		int stall;
		int pick;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (no_idle) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					stall = 0;
				else if (pick < 92)
					stall = $urandom_range(1, 3);
				else
					stall = $urandom_range(10, 40);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// gap before the next frame request
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// sample mix: full-scale extremes, values near the floor and near 1.0, the rest spread
	function automatic logic [SMP_W-1:0] rand_sample();
		logic [SMP_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				v = 24'h80_0000;
			end
			1: begin
				v = 24'h7F_FFFF;
			end
			2: begin
				v = SMP_W'($urandom_range(0, 64));
			end
			3: begin
				v = SMP_W'(ONE_Q20) + SMP_W'($urandom_range(0, 8)) - 24'd4;
			end
			4, 5, 6: begin
				v = SMP_W'($urandom);
			end
			default: begin
				v = SMP_W'($urandom_range(0, 1048575));
			end
		endcase
		if (v != 24'h80_0000 && v != 24'h7F_FFFF && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// one frame request; returns at the edge that takes it, valid still high
	task automatic send_frame(input logic [SMP_W-1:0] l, input logic [SMP_W-1:0] r,
		input logic rec);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, rec, r, l};
		do
			@(posedge clk);
		while (!s_tready);
		frames_sent++;
	endtask

	// hold the sender until every result is in, then give the pipe time to settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.checked < frames_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers in one back-to-back register sequence; block must be idle
	task automatic set_config(input logic stereo, input logic [MAG_W-1:0] floor_v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_STEREO, 2'b00};
		pwdata  <= {31'd0, stereo};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		paddr   <= {REG_FLOOR, 2'b00};
		pwdata  <= {9'd0, floor_v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.stereo  = stereo;
		sb.floor_q = floor_v;
		n_settings++;
	endtask

	initial begin
		logic [MAG_W-1:0] fl;
		sb = new();
		no_idle     = 1'b0;
		frames_sent = 0;
		n_settings  = 0;
		run_left    = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings (mono, floor 22): extremes and stops
		send_frame(24'h80_0000, 24'h7F_FFFF, 1'b1);
		send_frame(24'h7F_FFFF, 24'h80_0000, 1'b1);
		send_frame(24'h00_0000, 24'h00_0000, 1'b1);
		send_frame(24'hFF_FFFF, 24'h00_0001, 1'b1);
		// stop after a partial fill, then a stop while idle
		send_frame(24'h01_0000, 24'hFF_0000, 1'b0);
		send_frame(24'h00_0015, 24'h00_0016, 1'b0);
		// around 1.0 on both signs
		send_frame(24'h10_0000, 24'hF0_0000, 1'b1);
		send_frame(24'hF0_0000, 24'h10_0000, 1'b1);
		send_frame(24'h0F_FFFF, 24'hF0_0001, 1'b1);
		send_frame(24'h00_0000, 24'h00_0000, 1'b0);

		// directed, stereo with no floor
		wait_idle();
		set_config(1'b1, '0);
		send_frame(24'h00_0000, 24'h00_0000, 1'b1);
		send_frame(24'h80_0000, 24'h7F_FFFF, 1'b1);
		send_frame(24'hF0_0000, 24'h10_0000, 1'b1);
		send_frame(24'h55_5555, 24'hAA_AAAA, 1'b0);
		send_frame(24'hAA_AAAA, 24'h55_5555, 1'b0);

		// directed, floor at full scale
		wait_idle();
		set_config(1'b1, MAG_MAX);
		send_frame(24'h00_0001, 24'hFF_FFFF, 1'b1);
		send_frame(24'h00_0000, 24'h00_0000, 1'b0);

		// full rate, no idling: a mono word leaves the index odd, stereo pairs carry on
		// from there until a stop closes the run
		wait_idle();
		no_idle = 1'b1;
		fl = MAG_W'($urandom_range(0, 4096));
		set_config(1'b0, fl);
		send_frame(rand_sample(), rand_sample(), 1'b1);
		wait_idle();
		set_config(1'b1, fl);
		repeat (40) send_frame(rand_sample(), rand_sample(), 1'b1);
		send_frame(rand_sample(), rand_sample(), 1'b0);
		wait_idle();
		no_idle = 1'b0;

		// random part: recording runs of random length closed by stops, a few back-to-back
		// stops; settings change between segments, sometimes in the middle of a run
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg % 6)
				0: fl = '0;
				1: fl = MAG_MAX;
				2: fl = PEAK_FLOOR_RST;
				3: fl = ONE_Q20;
				4: fl = MAG_W'($urandom);
				default: fl = MAG_W'($urandom_range(0, 255));
			endcase
			wait_idle();
			set_config(seg[0] ^ 1'($urandom_range(0, 1)), fl);
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if (run_left > 0) begin
					send_frame(rand_sample(), rand_sample(), 1'b1);
					run_left--;
				end else begin
					send_frame(rand_sample(), rand_sample(), 1'b0);
					case ($urandom_range(0, 9))
						0: run_left = 0;
						9: run_left = $urandom_range(40, 150);
						default: run_left = $urandom_range(1, 20);
					endcase
				end
				// sender holds off mid-segment until the block has drained
				if (seg == SEG_COUNT / 2 && k == SEG_ITEMS / 2)
					wait_idle();
			end
		end

		wait_idle();
		sb.errors += sb.expected_q.size();
		$display("%0d frames over %0d register settings; %0d bank swaps, %0d closing flushes",
			frames_sent, n_settings, sb.n_swap, sb.n_close);
		$display("peak window latched %0d times, clip flag seen on %0d results",
			sb.n_latch, sb.n_clip);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
